### design/ctmc_pkg.sv
`default_nettype none
package ctmc_pkg;

    // Width of a path or tour cost and the value at which costs saturate.
    localparam int CostW = 23;
    localparam logic [CostW-1:0] CostMax = 23'h7FFFFF;

    // Controls how the relaxation unit forms its candidate value.
    typedef struct packed {
        logic sat_en;   // clamp the sum at CostMax
        logic base;     // candidate is the hop alone
    } t_relax_ctl;

endpackage
`default_nettype wire

### design/ctmc_relax.sv
`default_nettype none
module ctmc_relax #(
    parameter int SW = 23,
    parameter int TB = 16
) (
    input  logic [SW-1:0]          i_acc,
    input  logic [TB-1:0]          i_hop,
    input  logic [SW-1:0]          i_cur,
    input  ctmc_pkg::t_relax_ctl   i_ctl,
    output logic                   o_take,
    output logic [SW-1:0]          o_val
);

    logic [SW:0] sum;

    assign sum = {1'b0, i_acc} + (SW+1)'(i_hop);

    always_comb begin
        if (i_ctl.base) begin
            o_val  = SW'(i_hop);
            o_take = 1'b1;
        end else if (i_ctl.sat_en && (sum > (SW+1)'(ctmc_pkg::CostMax))) begin
            o_val  = SW'(ctmc_pkg::CostMax);
            o_take = (SW'(ctmc_pkg::CostMax) < i_cur);
        end else begin
            // Without clamping the full sum is compared, so an overflow of
            // the stored width never looks like an improvement.
            o_val  = sum[SW-1:0];
            o_take = (sum < {1'b0, i_cur});
        end
    end

endmodule
`default_nettype wire

### design/closed_tour_min_cost.sv
// Operation: an entry request is written while idle; a last request starts the closure
// over every pivot and node pair, then the subset pass over every subset and end location,
// then a final pass back to the depot whose minimum becomes the result.
// Throughput: one entry per cycle while loading; one tour at a time otherwise.
// Reset clears control and the location count (to 1); both memories are not
// cleared and hold whatever was last written.
`default_nettype none
module closed_tour_min_cost #(
    parameter int MAX_ORDERS = 10,
    parameter int TIME_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_from_loc,
    input  wire logic [3:0]  i_to_loc,
    input  wire logic [15:0] i_hop_time,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [22:0]      o_tour_time,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_num_orders
);

    // Node index width (depot plus locations), location index width, and the
    // width of a stored subset cost, which must also hold a raw hop time.
    localparam int NB = $clog2(MAX_ORDERS + 1);
    localparam int VB = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int MB = MAX_ORDERS;
    localparam int CW = ctmc_pkg::CostW;
    localparam int SW = (TIME_BITS > CW) ? TIME_BITS : CW;

    typedef enum logic [3:0] {
        S_IDLE, S_FW_IK, S_FW_IKW, S_FW_RD, S_FW_WR,
        S_DP_V, S_DP_RD, S_DP_ACC, S_DP_WB
    } t_state;

    // Hop matrix, addressed by {source, destination}. Two read ports: the
    // closure needs the row of the pivot and the entry it may improve.
    logic [TIME_BITS-1:0] dist_mem [2**(2*NB)];
    // Subset costs, addressed by {subset, end location}.
    logic [SW-1:0]        cost_mem [2**(MB+VB)];

    t_state               r_state;
    logic [3:0]           r_cfg;
    logic [NB-1:0]        r_n;
    logic [NB-1:0]        r_k, r_i, r_j, r_s;
    logic [VB-1:0]        r_v;
    logic [MB-1:0]        r_mask;
    logic                 r_fin;
    logic [TIME_BITS-1:0] r_dik;
    logic [SW-1:0]        r_c;
    logic                 r_ov;
    logic [CW-1:0]        r_out;
    logic [TIME_BITS-1:0] r_rda, r_rdb;
    logic [SW-1:0]        r_rdc;

    logic                 in_acc, in_range;
    logic [23:0]          hop_ext;
    logic [NB-1:0]        n_eff;
    logic [MB-1:0]        full_m1, rest;
    logic [NB-1:0]        e_node;
    logic [VB-1:0]        s_loc;
    logic                 s_ok, rest_zero;
    logic [2*NB-1:0]      addr_a, addr_b, addr_w;
    logic                 we_dist;
    logic [TIME_BITS-1:0] wd_dist;
    logic                 we_cost;
    ctmc_pkg::t_relax_ctl relax_ctl;
    logic [SW-1:0]        relax_acc, relax_cur, relax_val;
    logic [TIME_BITS-1:0] relax_hop;
    logic                 relax_take;

    // A last request waits while the previous tour is still undelivered;
    // plain entry requests keep flowing.
    assign o_in_ready  = (r_state == S_IDLE) && !(r_ov && i_is_last);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_tour_time = r_out;

    assign in_range = (int'(i_from_loc) <= MAX_ORDERS) && (int'(i_to_loc) <= MAX_ORDERS);
    assign hop_ext  = 24'(i_hop_time);

    // A location count of zero works as one; above the maximum it is clamped.
    assign n_eff = (r_cfg == 4'd0) ? NB'(1) :
                   (int'(r_cfg) > MAX_ORDERS) ? NB'(MAX_ORDERS) : NB'(r_cfg);

    assign full_m1 = ~({MB{1'b1}} << r_n);

    // The final pass reuses the subset step: all locations visited, ending
    // at the depot, and its minimum becomes the result instead of a write.
    assign rest      = r_fin ? full_m1 : (r_mask & ~(MB'(1) << r_v));
    assign rest_zero = (rest == '0);
    assign e_node    = r_fin ? '0 : NB'(r_v) + NB'(1);
    assign s_loc     = VB'(r_s - NB'(1));
    assign s_ok      = rest_zero ? (r_s == '0) : ((r_s != '0) && rest[s_loc]);

    always_comb begin
        addr_a  = {r_i, r_j};
        addr_b  = {r_k, r_j};
        addr_w  = {r_i, r_j};
        we_dist = 1'b0;
        wd_dist = relax_val[TIME_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                addr_w  = {i_from_loc[NB-1:0], i_to_loc[NB-1:0]};
                wd_dist = hop_ext[TIME_BITS-1:0];
                we_dist = in_acc && in_range;
            end
            S_FW_IK: addr_a = {r_i, r_k};
            S_FW_WR: we_dist = relax_take;
            S_DP_RD: addr_a = {r_s, e_node};
            default: ;
        endcase
    end

    assign we_cost = (r_state == S_DP_WB) && !r_fin;

    always_ff @(posedge i_clk) begin
        if (we_dist) begin
            dist_mem[addr_w] <= wd_dist;
        end
        r_rda <= dist_mem[addr_a];
        r_rdb <= dist_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (we_cost) begin
            cost_mem[{r_mask, r_v}] <= r_c;
        end
        r_rdc <= cost_mem[{rest, s_loc}];
    end

    // In the closure the operands are the pivot entries and the current entry;
    // in the subset pass they are the prior subset cost, the hop, and the
    // running minimum.
    always_comb begin
        if (r_state == S_FW_WR) begin
            relax_ctl = '{sat_en: 1'b0, base: 1'b0};
            relax_acc = SW'(r_dik);
            relax_hop = r_rdb;
            relax_cur = SW'(r_rda);
        end else begin
            relax_ctl = '{sat_en: 1'b1, base: rest_zero};
            relax_acc = r_rdc;
            relax_hop = r_rda;
            relax_cur = r_c;
        end
    end

    ctmc_relax #(.SW(SW), .TB(TIME_BITS)) u_relax (
        .i_acc  (relax_acc),
        .i_hop  (relax_hop),
        .i_cur  (relax_cur),
        .i_ctl  (relax_ctl),
        .o_take (relax_take),
        .o_val  (relax_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= 4'd1;
            r_ov    <= 1'b0;
            r_n     <= NB'(1);
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_s     <= '0;
            r_v     <= '0;
            r_mask  <= MB'(1);
            r_fin   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_num_orders;
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_is_last) begin
                        r_n     <= n_eff;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_FW_IK;
                    end
                end
                S_FW_IK: r_state <= S_FW_IKW;
                S_FW_IKW: begin
                    r_dik   <= r_rda;
                    r_state <= S_FW_RD;
                end
                S_FW_RD: r_state <= S_FW_WR;
                S_FW_WR: begin
                    if (r_j != r_n) begin
                        r_j     <= r_j + NB'(1);
                        r_state <= S_FW_RD;
                    end else begin
                        r_j <= '0;
                        if (r_i != r_n) begin
                            r_i     <= r_i + NB'(1);
                            r_state <= S_FW_IK;
                        end else begin
                            r_i <= '0;
                            if (r_k != r_n) begin
                                r_k     <= r_k + NB'(1);
                                r_state <= S_FW_IK;
                            end else begin
                                r_mask  <= MB'(1);
                                r_v     <= '0;
                                r_fin   <= 1'b0;
                                r_state <= S_DP_V;
                            end
                        end
                    end
                end
                S_DP_V: begin
                    r_c <= SW'(ctmc_pkg::CostMax);
                    r_s <= '0;
                    if (r_fin || r_mask[r_v]) begin
                        r_state <= S_DP_RD;
                    end else begin
                        // End location outside the subset: nothing to compute.
                        if (NB'(r_v) == r_n - NB'(1)) begin
                            r_v <= '0;
                            if (r_mask == full_m1) begin
                                r_fin <= 1'b1;
                            end else begin
                                r_mask <= r_mask + MB'(1);
                            end
                        end else begin
                            r_v <= r_v + VB'(1);
                        end
                    end
                end
                S_DP_RD: begin
                    if (s_ok) begin
                        r_state <= S_DP_ACC;
                    end else if (r_s == r_n) begin
                        r_state <= S_DP_WB;
                    end else begin
                        r_s <= r_s + NB'(1);
                    end
                end
                S_DP_ACC: begin
                    if (relax_take) begin
                        r_c <= relax_val;
                    end
                    if (r_s == r_n) begin
                        r_state <= S_DP_WB;
                    end else begin
                        r_s     <= r_s + NB'(1);
                        r_state <= S_DP_RD;
                    end
                end
                S_DP_WB: begin
                    if (r_fin) begin
                        r_ov    <= 1'b1;
                        r_out   <= r_c[CW-1:0];
                        r_fin   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DP_V;
                        if (NB'(r_v) == r_n - NB'(1)) begin
                            r_v <= '0;
                            if (r_mask == full_m1) begin
                                r_fin <= 1'b1;
                            end else begin
                                r_mask <= r_mask + MB'(1);
                            end
                        end else begin
                            r_v <= r_v + VB'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
